### rtl/core/rscb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rscb_pkg
// Shared constants, register indexes and types of the clipped sprite blitter.
// ----------------------------------------------------------------------------
package rscb_pkg;

   localparam int COORD_BITS     = 13;
   localparam int COUNT_BITS     = 24;
   localparam int POS_BITS       = COORD_BITS - 1;
   localparam int PITCH_BITS     = 14;
   localparam int ADDR_BITS      = 32;
   localparam int PIX_BITS       = 8;
   localparam int HDR_BITS       = 3;
   localparam int HEADER_BYTES   = 4;
   localparam int INDEX_BITS     = COUNT_BITS + 1;
   localparam int Y_BITS         = COUNT_BITS + 2;
   localparam int PROD_BITS      = COORD_BITS + PITCH_BITS;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [PIX_BITS-1:0]   SKIP_MARK        = 8'h80;
   localparam logic [COORD_BITS-1:0] MAX_SPRITE_WIDTH = COORD_BITS'(1) << POS_BITS;
   localparam logic [COUNT_BITS-1:0] ROW_MAX          = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPRITE_WIDTH = 3'd0,
      CSR_PIXEL_TOTAL  = 3'd1,
      CSR_DEST_PITCH   = 3'd2,
      CSR_OFFSET_X     = 3'd3,
      CSR_OFFSET_Y     = 3'd4,
      CSR_CLIP_WIDTH   = 3'd5,
      CSR_CLIP_HEIGHT  = 3'd6,
      CSR_DEST_BASE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] sprite_width;
      logic [COUNT_BITS-1:0] pixel_total;
      logic [PITCH_BITS-1:0] dest_pitch;
      logic [COORD_BITS-1:0] offset_x;
      logic [COORD_BITS-1:0] offset_y;
      logic [COORD_BITS-1:0] clip_width;
      logic [COORD_BITS-1:0] clip_height;
      logic [ADDR_BITS-1:0]  dest_base;
   } cfg_type;

   // One classified byte on its way to the address stage.
   typedef struct packed {
      logic                  we;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [PIX_BITS-1:0]   pix;
      logic                  done;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage
`default_nettype wire

### rtl/core/rle_sprite_clipped_blit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_sprite_clipped_blit
// Clipped blit of a run-length coded sprite, one coded byte per request.
// ----------------------------------------------------------------------------
// Each request carries one coded sprite byte and gives exactly one response
// with the write enable, destination address, pixel and end-of-image flag.
// The block takes one byte per clock cycle in steady state: the decoder
// updates its header, run and position counters in the cycle the request is
// accepted and hands the byte to a four-entry queue; the address stage forms
// row times pitch in one register stage and adds base and column in the
// output register, so a response passes the queue, the product register and
// the output register, in that order. The request side stalls only when the
// queue is full, which happens when the response side has been stalled.
// Registers are written through the csr port, which is always ready, and
// should be changed only while no request is in flight.
// ----------------------------------------------------------------------------
module rle_sprite_clipped_blit
   import rscb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [PIX_BITS-1:0]       req_rle_byte,
   input  wire logic                      req_start_of_image,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_write_enable,
   output logic [ADDR_BITS-1:0]           rsp_write_address,
   output logic [PIX_BITS-1:0]            rsp_pixel_value,
   output logic                           rsp_image_done,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type          cfg_ff;
   queue_status_type status;
   item_type         front_item;
   item_type         head_item;
   logic             accept;
   logic             pop;
   csr_index_type    csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sprite_width <= COORD_BITS'(1);
         cfg_ff.pixel_total  <= '0;
         cfg_ff.dest_pitch   <= PITCH_BITS'(1);
         cfg_ff.offset_x     <= '0;
         cfg_ff.offset_y     <= '0;
         cfg_ff.clip_width   <= '0;
         cfg_ff.clip_height  <= '0;
         cfg_ff.dest_base    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            CSR_SPRITE_WIDTH: cfg_ff.sprite_width <= csr_wdata[COORD_BITS-1:0];
            CSR_PIXEL_TOTAL:  cfg_ff.pixel_total  <= csr_wdata[COUNT_BITS-1:0];
            CSR_DEST_PITCH:   cfg_ff.dest_pitch   <= csr_wdata[PITCH_BITS-1:0];
            CSR_OFFSET_X:     cfg_ff.offset_x     <= csr_wdata[COORD_BITS-1:0];
            CSR_OFFSET_Y:     cfg_ff.offset_y     <= csr_wdata[COORD_BITS-1:0];
            CSR_CLIP_WIDTH:   cfg_ff.clip_width   <= csr_wdata[COORD_BITS-1:0];
            CSR_CLIP_HEIGHT:  cfg_ff.clip_height  <= csr_wdata[COORD_BITS-1:0];
            CSR_DEST_BASE:    cfg_ff.dest_base    <= csr_wdata[ADDR_BITS-1:0];
            default:          cfg_ff.dest_base    <= cfg_ff.dest_base;
         endcase
      end
   end

   rscb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (accept),
      .rle_byte       (req_rle_byte),
      .start_of_image (req_start_of_image),
      .item           (front_item)
   );

   rscb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (status)
   );

   rscb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .status            (status),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_image_done    (rsp_image_done)
   );

endmodule
`default_nettype wire

### rtl/core/rscb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rscb_front
// Decoder: tracks header, runs and sprite position, and classifies each byte.
// ----------------------------------------------------------------------------
module rscb_front
   import rscb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                accept,
   input  wire logic [PIX_BITS-1:0] rle_byte,
   input  wire logic                start_of_image,
   output item_type                 item
);

   logic [HDR_BITS-1:0]   header_left_ff, header_left_in;
   logic [PIX_BITS-1:0]   literal_left_ff, literal_left_in;
   logic [INDEX_BITS-1:0] pixel_index_ff, pixel_index_in;
   logic [POS_BITS-1:0]   sprite_column_ff, sprite_column_in;
   logic [COUNT_BITS-1:0] sprite_row_ff, sprite_row_in;
   logic                  finished_ff, finished_in;

   logic [HDR_BITS-1:0]   hl;
   logic [PIX_BITS-1:0]   ll;
   logic [INDEX_BITS-1:0] pi;
   logic [POS_BITS-1:0]   col;
   logic [COUNT_BITS-1:0] row;
   logic                  fin;

   logic [COORD_BITS-1:0] width_eff;
   logic [PIX_BITS-1:0]   adv_n;
   logic [INDEX_BITS-1:0] pi_adv;
   logic [COORD_BITS-1:0] col_sum;
   logic [COORD_BITS-1:0] col_wrap;
   logic [POS_BITS-1:0]   col_adv;
   logic [COUNT_BITS-1:0] row_adv;
   logic                  adv_end;
   logic [COORD_BITS:0]   x_pos;
   logic [Y_BITS-1:0]     y_pos;
   logic                  x_visible;
   logic                  is_skip;

   always_comb begin
      // A start marker restarts decoding before this byte is handled.
      hl  = start_of_image ? HDR_BITS'(HEADER_BYTES) : header_left_ff;
      ll  = start_of_image ? '0 : literal_left_ff;
      pi  = start_of_image ? '0 : pixel_index_ff;
      col = start_of_image ? '0 : sprite_column_ff;
      row = start_of_image ? '0 : sprite_row_ff;
      fin = start_of_image ? 1'b0 : finished_ff;

      if (cfg.sprite_width == '0) begin
         width_eff = COORD_BITS'(1);
      end else if (cfg.sprite_width > MAX_SPRITE_WIDTH) begin
         width_eff = MAX_SPRITE_WIDTH;
      end else begin
         width_eff = cfg.sprite_width;
      end

      // Inside a literal run the position moves by one, on a skip by the count.
      adv_n   = (ll != '0) ? PIX_BITS'(1) : {1'b0, rle_byte[PIX_BITS-2:0]};
      pi_adv  = pi + INDEX_BITS'(adv_n);
      col_sum = {1'b0, col} + COORD_BITS'(adv_n);
      row_adv = row;
      col_wrap = col_sum;
      if (col_sum >= width_eff) begin
         col_wrap = col_sum - width_eff;
         if (row != ROW_MAX) begin
            row_adv = row + COUNT_BITS'(1);
         end
         if (col_wrap >= width_eff) begin
            col_wrap = '0;
         end
      end
      col_adv = col_wrap[POS_BITS-1:0];
      adv_end = pi_adv >= {1'b0, cfg.pixel_total};

      x_pos = {2'b00, col} + {cfg.offset_x[COORD_BITS-1], cfg.offset_x};
      y_pos = {2'b00, row} + {{(Y_BITS-COORD_BITS){cfg.offset_y[COORD_BITS-1]}},
                              cfg.offset_y};
      x_visible = !x_pos[COORD_BITS] && (x_pos[COORD_BITS-1:0] < cfg.clip_width);
      is_skip = rle_byte[PIX_BITS-1] &&
                ((COORD_BITS+1)'(rle_byte) <=
                 ((COORD_BITS+1)'(SKIP_MARK) + (COORD_BITS+1)'(width_eff)));

      header_left_in   = hl;
      literal_left_in  = ll;
      pixel_index_in   = pi;
      sprite_column_in = col;
      sprite_row_in    = row;
      finished_in      = fin;
      item.we          = 1'b0;

      if (!fin) begin
         if (hl != '0) begin
            header_left_in = hl - HDR_BITS'(1);
            if (hl == HDR_BITS'(1) && pi >= {1'b0, cfg.pixel_total}) begin
               finished_in = 1'b1;
            end
         end else if (ll != '0) begin
            if (x_visible && !y_pos[Y_BITS-1] &&
                y_pos[Y_BITS-2:0] >= (Y_BITS-1)'(cfg.clip_height)) begin
               // Reaching the rows below the window ends the image.
               finished_in = 1'b1;
            end else begin
               item.we          = x_visible && !y_pos[Y_BITS-1];
               pixel_index_in   = pi_adv;
               sprite_column_in = col_adv;
               sprite_row_in    = row_adv;
               literal_left_in  = ll - PIX_BITS'(1);
               if (ll == PIX_BITS'(1) && adv_end) begin
                  finished_in = 1'b1;
               end
            end
         end else if (pi >= {1'b0, cfg.pixel_total}) begin
            finished_in = 1'b1;
         end else if (is_skip) begin
            pixel_index_in   = pi_adv;
            sprite_column_in = col_adv;
            sprite_row_in    = row_adv;
            finished_in      = adv_end;
         end else begin
            literal_left_in = rle_byte;
         end
      end

      item.x    = x_pos[COORD_BITS-1:0];
      item.y    = y_pos[COORD_BITS-1:0];
      item.pix  = rle_byte;
      item.done = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_left_ff   <= HDR_BITS'(HEADER_BYTES);
         literal_left_ff  <= '0;
         pixel_index_ff   <= '0;
         sprite_column_ff <= '0;
         sprite_row_ff    <= '0;
         finished_ff      <= 1'b0;
      end else if (accept) begin
         header_left_ff   <= header_left_in;
         literal_left_ff  <= literal_left_in;
         pixel_index_ff   <= pixel_index_in;
         sprite_column_ff <= sprite_column_in;
         sprite_row_ff    <= sprite_row_in;
         finished_ff      <= finished_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/rscb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rscb_queue
// Short queue of classified bytes between the decoder and the address stage.
// ----------------------------------------------------------------------------
module rscb_queue
   import rscb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire item_type   push_item,
   input  wire logic       pop,
   output item_type        head_item,
   output queue_status_type status
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS:0]     count_ff;

   assign head_item        = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_BITS+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_BITS+1)'(1);
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full && !pop |-> !push)
      else $error("request pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("pop from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count past its depth");
`endif

endmodule
`default_nettype wire

### rtl/core/rscb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rscb_back
// Address stage: row times pitch, then base and column added, output register.
// ----------------------------------------------------------------------------
module rscb_back
   import rscb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire queue_status_type      status,
   input  wire item_type              head_item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_write_enable,
   output logic [ADDR_BITS-1:0]       rsp_write_address,
   output logic [PIX_BITS-1:0]        rsp_pixel_value,
   output logic                       rsp_image_done
);

   logic                   s1_valid_ff;
   logic                   s1_we_ff;
   logic [PROD_BITS-1:0]   s1_prod_ff;
   logic [COORD_BITS-1:0]  s1_x_ff;
   logic [PIX_BITS-1:0]    s1_pix_ff;
   logic                   s1_done_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_we_ff;
   logic [ADDR_BITS-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [PIX_BITS-1:0]    rsp_pix_ff;
   logic                   rsp_done_ff;

   logic                   out_adv;
   logic                   s1_load;

   assign out_adv = !rsp_valid_ff || !rsp_stall;
   assign s1_load = !s1_valid_ff || out_adv;
   assign pop     = status.not_empty && s1_load;

   assign rsp_addr_in = cfg.dest_base + ADDR_BITS'(s1_prod_ff) + ADDR_BITS'(s1_x_ff);

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_we_ff   <= head_item.we;
         s1_prod_ff <= PROD_BITS'(head_item.y) * PROD_BITS'(cfg.dest_pitch);
         s1_x_ff    <= head_item.x;
         s1_pix_ff  <= head_item.pix;
         s1_done_ff <= head_item.done;
      end
      if (out_adv) begin
         rsp_we_ff   <= s1_we_ff;
         rsp_addr_ff <= s1_we_ff ? rsp_addr_in : '0;
         rsp_pix_ff  <= s1_we_ff ? s1_pix_ff : '0;
         rsp_done_ff <= s1_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= pop;
         end
         if (out_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_pixel_value   = rsp_pix_ff;
   assign rsp_image_done    = rsp_done_ff;

`ifndef ASSERT_OFF
   a_idle_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_we_ff |-> rsp_addr_ff == '0 && rsp_pix_ff == '0)
      else $error("address or pixel nonzero on a request without a write");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_adv |=> s1_valid_ff && $stable(s1_prod_ff))
      else $error("product stage changed while the output was stalled");

   a_pop_fills_s1: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_valid_ff)
      else $error("popped request lost before the product stage");
`endif

endmodule
`default_nettype wire
